[rtl/core/swd_pkg.sv]
// Shared types, constants and microcode encodings for the successor-with-delete block.
package swd_pkg;

   localparam int TABLE_SIZE_DEFAULT = 1024;
   localparam int IDX_W = 10;

   typedef struct packed {
      logic             command;
      logic [IDX_W-1:0] index_value;
   } req_item_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] successor_index;
   } rsp_item_type;

   localparam logic CMD_REMOVE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // Microprogram step addresses.
   typedef logic [4:0] pc_type;

   localparam pc_type ST_R_READ     = 5'd0;
   localparam pc_type ST_R_MARK     = 5'd1;
   localparam pc_type ST_R_LO_RD    = 5'd2;
   localparam pc_type ST_R_LO_CHK   = 5'd3;
   localparam pc_type ST_R_LO_FA    = 5'd4;
   localparam pc_type ST_R_LO_B     = 5'd5;
   localparam pc_type ST_R_LO_FB    = 5'd6;
   localparam pc_type ST_R_LO_CMP   = 5'd7;
   localparam pc_type ST_R_LO_LINK  = 5'd8;
   localparam pc_type ST_R_LO_MERGE = 5'd9;
   localparam pc_type ST_R_HI       = 5'd10;
   localparam pc_type ST_R_HI_CHK   = 5'd11;
   localparam pc_type ST_R_HI_FA    = 5'd12;
   localparam pc_type ST_R_HI_B     = 5'd13;
   localparam pc_type ST_R_HI_FB    = 5'd14;
   localparam pc_type ST_R_HI_CMP   = 5'd15;
   localparam pc_type ST_R_HI_LINK  = 5'd16;
   localparam pc_type ST_R_HI_MERGE = 5'd17;
   localparam pc_type ST_END        = 5'd18;
   localparam pc_type ST_Q_READ     = 5'd19;
   localparam pc_type ST_Q_CHK      = 5'd20;
   localparam pc_type ST_Q_FIND     = 5'd21;
   localparam pc_type ST_Q_LAST     = 5'd22;
   localparam pc_type ST_Q_NEXT     = 5'd23;
   localparam pc_type ST_Q_SELF     = 5'd24;
   localparam pc_type ST_Q_NONE     = 5'd25;
   localparam pc_type ST_LAST       = ST_Q_NONE;

   typedef enum logic [2:0] {
      MEM_IDLE,
      MEM_READ,
      MEM_MARK,
      MEM_LINK,
      MEM_MERGE
   } mem_op_type;

   typedef enum logic [2:0] {
      ADDR_X,
      ADDR_XLO,
      ADDR_XHI,
      ADDR_PARENT,
      ADDR_SMALL,
      ADDR_BIG
   } addr_sel_type;

   typedef enum logic [1:0] {
      ROOT_NONE,
      ROOT_A,
      ROOT_B
   } root_ld_type;

   typedef enum logic [1:0] {
      EMIT_OFF,
      EMIT_SELF,
      EMIT_NEXT,
      EMIT_NONE
   } emit_type;

   typedef enum logic [3:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_OOR,
      COND_NO_LOW,
      COND_NO_HIGH,
      COND_NOT_DEL,
      COND_NOT_ROOT,
      COND_SAME_ROOT,
      COND_NO_SUCC
   } cond_type;

   typedef struct packed {
      mem_op_type   mem_op;
      addr_sel_type addr_sel;
      logic         node_ld;
      root_ld_type  root_ld;
      emit_type     emit;
      cond_type     cond;
      pc_type       target;
      logic         done;
   } ucode_word_type;

   localparam ucode_word_type UCODE_NOP = '{
      mem_op:   MEM_IDLE,
      addr_sel: ADDR_X,
      node_ld:  1'b0,
      root_ld:  ROOT_NONE,
      emit:     EMIT_OFF,
      cond:     COND_NONE,
      target:   ST_R_READ,
      done:     1'b0
   };

   typedef struct packed {
      logic oor;
      logic no_low;
      logic no_high;
      logic not_del;
      logic not_root;
      logic same_root;
      logic no_succ;
      logic clear_last;
   } status_type;

   typedef struct packed {
      logic           accept;
      logic           clear_en;
      ucode_word_type ucode;
   } seq_ctrl_type;

   typedef enum logic [1:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

endpackage

[rtl/core/swd_ucode_rom.sv]
// Microcode read-only table: one control word for each program step.
module swd_ucode_rom (
   input  swd_pkg::pc_type         pc,
   output swd_pkg::ucode_word_type ucode
);
   import swd_pkg::*;

   always_comb begin
      ucode = UCODE_NOP;
      case (pc)
         // Remove: read the entry, then mark it deleted.
         ST_R_READ: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_X;
            ucode.cond     = COND_OOR;
            ucode.target   = ST_END;
         end
         ST_R_MARK: begin
            ucode.mem_op   = MEM_MARK;
            ucode.addr_sel = ADDR_X;
            ucode.cond     = COND_NO_LOW;
            ucode.target   = ST_R_HI;
         end
         // Join with the lower neighbor when it is deleted.
         ST_R_LO_RD: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_XLO;
         end
         ST_R_LO_CHK: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_X;
            ucode.node_ld  = 1'b1;
            ucode.cond     = COND_NOT_DEL;
            ucode.target   = ST_R_HI;
         end
         ST_R_LO_FA: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_PARENT;
            ucode.node_ld  = 1'b1;
            ucode.root_ld  = ROOT_A;
            ucode.cond     = COND_NOT_ROOT;
            ucode.target   = ST_R_LO_FA;
         end
         ST_R_LO_B: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_XLO;
            ucode.node_ld  = 1'b1;
         end
         ST_R_LO_FB: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_PARENT;
            ucode.node_ld  = 1'b1;
            ucode.root_ld  = ROOT_B;
            ucode.cond     = COND_NOT_ROOT;
            ucode.target   = ST_R_LO_FB;
         end
         ST_R_LO_CMP: begin
            ucode.cond   = COND_SAME_ROOT;
            ucode.target = ST_R_HI;
         end
         ST_R_LO_LINK: begin
            ucode.mem_op   = MEM_LINK;
            ucode.addr_sel = ADDR_SMALL;
         end
         ST_R_LO_MERGE: begin
            ucode.mem_op   = MEM_MERGE;
            ucode.addr_sel = ADDR_BIG;
         end
         // Join with the upper neighbor when it is deleted.
         ST_R_HI: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_XHI;
            ucode.cond     = COND_NO_HIGH;
            ucode.target   = ST_END;
         end
         ST_R_HI_CHK: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_X;
            ucode.node_ld  = 1'b1;
            ucode.cond     = COND_NOT_DEL;
            ucode.target   = ST_END;
         end
         ST_R_HI_FA: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_PARENT;
            ucode.node_ld  = 1'b1;
            ucode.root_ld  = ROOT_A;
            ucode.cond     = COND_NOT_ROOT;
            ucode.target   = ST_R_HI_FA;
         end
         ST_R_HI_B: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_XHI;
            ucode.node_ld  = 1'b1;
         end
         ST_R_HI_FB: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_PARENT;
            ucode.node_ld  = 1'b1;
            ucode.root_ld  = ROOT_B;
            ucode.cond     = COND_NOT_ROOT;
            ucode.target   = ST_R_HI_FB;
         end
         ST_R_HI_CMP: begin
            ucode.cond   = COND_SAME_ROOT;
            ucode.target = ST_END;
         end
         ST_R_HI_LINK: begin
            ucode.mem_op   = MEM_LINK;
            ucode.addr_sel = ADDR_SMALL;
         end
         ST_R_HI_MERGE: begin
            ucode.mem_op   = MEM_MERGE;
            ucode.addr_sel = ADDR_BIG;
            ucode.done     = 1'b1;
         end
         ST_END: begin
            ucode.done = 1'b1;
         end
         // Query: out-of-range indices answer none, present entries answer themselves, else walk to the root.
         ST_Q_READ: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_X;
            ucode.node_ld  = 1'b1;
            ucode.cond     = COND_OOR;
            ucode.target   = ST_Q_NONE;
         end
         ST_Q_CHK: begin
            ucode.cond   = COND_NOT_DEL;
            ucode.target = ST_Q_SELF;
         end
         ST_Q_FIND: begin
            ucode.mem_op   = MEM_READ;
            ucode.addr_sel = ADDR_PARENT;
            ucode.node_ld  = 1'b1;
            ucode.root_ld  = ROOT_A;
            ucode.cond     = COND_NOT_ROOT;
            ucode.target   = ST_Q_FIND;
         end
         ST_Q_LAST: begin
            ucode.cond   = COND_NO_SUCC;
            ucode.target = ST_Q_NONE;
         end
         ST_Q_NEXT: begin
            ucode.emit = EMIT_NEXT;
            ucode.done = 1'b1;
         end
         ST_Q_SELF: begin
            ucode.emit = EMIT_SELF;
            ucode.done = 1'b1;
         end
         ST_Q_NONE: begin
            ucode.emit = EMIT_NONE;
            ucode.done = 1'b1;
         end
         default: begin
            ucode.done = 1'b1;
         end
      endcase
   end

endmodule

[rtl/core/swd_sequencer.sv]
// Step counter, conditional jumps and run control for the microprogram.
module swd_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    command,
   input  swd_pkg::status_type     status,
   input  swd_pkg::ucode_word_type rom_word,
   output swd_pkg::pc_type         pc,
   output logic                    busy,
   output swd_pkg::seq_ctrl_type   ctrl
);
   import swd_pkg::*;

   seq_state_type state_ff, state_in;
   pc_type        pc_ff, pc_in;
   logic          jump_hit;
   logic          run;
   logic          accept;

   always_comb begin
      case (rom_word.cond)
         COND_NONE:      jump_hit = 1'b0;
         COND_ALWAYS:    jump_hit = 1'b1;
         COND_OOR:       jump_hit = status.oor;
         COND_NO_LOW:    jump_hit = status.no_low;
         COND_NO_HIGH:   jump_hit = status.no_high;
         COND_NOT_DEL:   jump_hit = status.not_del;
         COND_NOT_ROOT:  jump_hit = status.not_root;
         COND_SAME_ROOT: jump_hit = status.same_root;
         COND_NO_SUCC:   jump_hit = status.no_succ;
         default:        jump_hit = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_CLEAR: if (status.clear_last) state_in = SEQ_IDLE;
         SEQ_IDLE:  if (start) state_in = SEQ_RUN;
         SEQ_RUN:   if (rom_word.done) state_in = SEQ_IDLE;
         default:   state_in = SEQ_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      busy          = (state_ff != SEQ_IDLE);
      run           = (state_ff == SEQ_RUN);
      accept        = start && (state_ff == SEQ_IDLE);
      ctrl.accept   = accept;
      ctrl.clear_en = (state_ff == SEQ_CLEAR);
      ctrl.ucode    = run ? rom_word : UCODE_NOP;
   end

   always_comb begin
      pc_in = pc_ff;
      if (accept) begin
         pc_in = (command == CMD_QUERY) ? ST_Q_READ : ST_R_READ;
      end else if (run && !rom_word.done) begin
         pc_in = jump_hit ? rom_word.target : pc_type'(pc_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_CLEAR;
         pc_ff    <= ST_R_READ;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   assign pc = pc_ff;

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN) |-> (pc_ff <= ST_LAST))
      else $error("step counter left the program");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == SEQ_RUN) && (pc_ff == ST_Q_READ || pc_ff == ST_R_READ))
      else $error("accepted command did not enter its program");

   a_done_idles: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN && rom_word.done) |=> (state_ff == SEQ_IDLE))
      else $error("program end did not return to idle");

endmodule

[rtl/core/swd_datapath.sv]
// Union-find record memory, walk registers, clearing sweep and result register.
module swd_datapath #(
   parameter int TABLE_SIZE = swd_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swd_pkg::seq_ctrl_type ctrl,
   input  logic [swd_pkg::IDX_W-1:0] index_value,
   output swd_pkg::status_type   status,
   output logic                  rsp_strobe,
   output swd_pkg::rsp_item_type rsp_item
);
   import swd_pkg::*;

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int WW = IW + 1;
   localparam int XW = ((IW > IDX_W) ? IW : IDX_W) + 1;
   localparam logic [XW-1:0] LAST_WIDE = XW'(TABLE_SIZE - 1);
   localparam logic [IW-1:0] LAST      = IW'(TABLE_SIZE - 1);

   typedef struct packed {
      logic          deleted;
      logic [IW-1:0] parent;
      logic [IW-1:0] largest;
      logic [WW-1:0] weight;
   } rec_type;

   rec_type mem_array [TABLE_SIZE];

   ucode_word_type   ucode;
   logic [IDX_W-1:0] x_ff, x_in;
   logic [IW-1:0]    node_ff, node_in;
   logic [IW-1:0]    ra_ff, ra_in;
   logic [IW-1:0]    rb_ff, rb_in;
   rec_type          rec_a_ff, rec_a_in;
   rec_type          rec_b_ff, rec_b_in;
   rec_type          rd_ff;
   logic [IW-1:0]    clr_ff, clr_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic [XW-1:0] x_wide;
   logic [IW-1:0] x_addr;
   logic [IW-1:0] mem_addr;
   logic          a_small;
   logic [IW-1:0] small_addr, big_addr;
   rec_type       small_rec, big_rec;
   logic          rd_en, wr_en;
   logic [IW-1:0] wr_addr;
   rec_type       wr_data;
   logic [XW-1:0] succ_wide;

   assign ucode  = ctrl.ucode;
   assign x_wide = XW'(x_ff);
   assign x_addr = x_wide[IW-1:0];

   // The lighter root is hung below the heavier one; ties keep the first root on top.
   assign a_small    = (rec_a_ff.weight < rec_b_ff.weight);
   assign small_addr = a_small ? ra_ff : rb_ff;
   assign big_addr   = a_small ? rb_ff : ra_ff;
   assign small_rec  = a_small ? rec_a_ff : rec_b_ff;
   assign big_rec    = a_small ? rec_b_ff : rec_a_ff;

   assign succ_wide = XW'(rec_a_ff.largest) + XW'(1);

   always_comb begin
      status.oor        = (x_wide > LAST_WIDE);
      status.no_low     = (x_wide == '0);
      status.no_high    = (x_wide == LAST_WIDE);
      status.not_del    = !rd_ff.deleted;
      status.not_root   = (rd_ff.parent != node_ff);
      status.same_root  = (ra_ff == rb_ff);
      status.no_succ    = (rec_a_ff.largest == LAST);
      status.clear_last = (clr_ff == LAST);
   end

   always_comb begin
      case (ucode.addr_sel)
         ADDR_X:      mem_addr = x_addr;
         ADDR_XLO:    mem_addr = IW'(x_addr - 1'b1);
         ADDR_XHI:    mem_addr = IW'(x_addr + 1'b1);
         ADDR_PARENT: mem_addr = rd_ff.parent;
         ADDR_SMALL:  mem_addr = small_addr;
         ADDR_BIG:    mem_addr = big_addr;
         default:     mem_addr = x_addr;
      endcase
   end

   always_comb begin
      rd_en   = (ucode.mem_op == MEM_READ);
      wr_en   = 1'b0;
      wr_addr = mem_addr;
      wr_data = rd_ff;
      if (ctrl.clear_en) begin
         wr_en           = 1'b1;
         wr_addr         = clr_ff;
         wr_data.deleted = 1'b0;
         wr_data.parent  = clr_ff;
         wr_data.largest = clr_ff;
         wr_data.weight  = WW'(1);
      end else begin
         case (ucode.mem_op)
            MEM_MARK: begin
               wr_en           = 1'b1;
               wr_data.deleted = 1'b1;
            end
            MEM_LINK: begin
               wr_en          = 1'b1;
               wr_data        = small_rec;
               wr_data.parent = big_addr;
            end
            MEM_MERGE: begin
               wr_en          = 1'b1;
               wr_data        = big_rec;
               wr_data.weight = WW'(rec_a_ff.weight + rec_b_ff.weight);
               if (small_rec.largest > big_rec.largest) begin
                  wr_data.largest = small_rec.largest;
               end
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_array[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem_array[mem_addr];
   end

   always_comb begin
      x_in     = ctrl.accept ? index_value : x_ff;
      node_in  = ucode.node_ld ? mem_addr : node_ff;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      rec_a_in = rec_a_ff;
      rec_b_in = rec_b_ff;
      case (ucode.root_ld)
         ROOT_A: begin
            ra_in    = node_ff;
            rec_a_in = rd_ff;
         end
         ROOT_B: begin
            rb_in    = node_ff;
            rec_b_in = rd_ff;
         end
         default: begin
            ra_in = ra_ff;
         end
      endcase
      clr_in = ctrl.clear_en ? IW'(clr_ff + 1'b1) : clr_ff;
   end

   always_comb begin
      rsp_strobe_in = (ucode.emit != EMIT_OFF);
      rsp_item_in   = rsp_item_ff;
      case (ucode.emit)
         EMIT_SELF: begin
            rsp_item_in.found           = 1'b1;
            rsp_item_in.successor_index = x_ff;
         end
         EMIT_NEXT: begin
            rsp_item_in.found           = 1'b1;
            rsp_item_in.successor_index = succ_wide[IDX_W-1:0];
         end
         EMIT_NONE: begin
            rsp_item_in.found           = 1'b0;
            rsp_item_in.successor_index = '0;
         end
         default: rsp_item_in = rsp_item_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      node_ff     <= node_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rec_a_ff    <= rec_a_in;
      rec_b_ff    <= rec_b_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_link_distinct: assert property (@(posedge clock) disable iff (reset)
      (ucode.mem_op == MEM_LINK) |-> (ra_ff != rb_ff))
      else $error("link written between equal roots");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (ucode.mem_op == MEM_MARK) |-> !status.oor)
      else $error("out-of-range index marked deleted");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_en |-> (ucode.mem_op == MEM_IDLE && ucode.emit == EMIT_OFF))
      else $error("program step ran during the clearing sweep");

endmodule

[rtl/core/successor_with_delete.sv]
// Top level of the successor-with-delete block: sequencer, microcode table and datapath.
//
// Usage. The block keeps the set of indices 0..TABLE_SIZE-1, all present after
// reset. A command transfer is taken at a rising edge where start is high and busy
// is low; req_item carries the command (remove or query) and the index.
// A remove deletes the index and joins it with deleted neighbors; it gives no
// result. A query gives one result transfer: rsp_strobe is high for exactly one
// cycle with rsp_item holding found and the smallest present index not below the
// query. The receiver cannot stall, so each result must be taken when shown.
//
// Operation. Each command runs as a short microprogram with at most one memory access
// per step, against a single record memory with one read and one write port. A query
// of a present index answers from its own record; a query of a deleted index walks
// parent links to its group root. A remove walks the group trees it joins; a tree's
// depth is at most log2 of TABLE_SIZE under weighted union. The result strobe is
// registered and rises in the cycle after the last step, and busy drops in that same
// cycle, so the next command can be taken while the result is shown.
//
// Reset. After reset a clearing sweep writes every record, one per cycle; busy stays
// high until it is done.
module successor_with_delete #(
   parameter int TABLE_SIZE = swd_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  swd_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output swd_pkg::rsp_item_type rsp_item
);
   import swd_pkg::*;

   pc_type         pc;
   ucode_word_type rom_word;
   status_type     status;
   seq_ctrl_type   ctrl;

   // The step counter addresses the microcode table; the selected control word
   // goes back to the sequencer for its jump test and on to the datapath.
   swd_ucode_rom u_rom (
      .pc    (pc),
      .ucode (rom_word)
   );

   // The sequencer controls the clearing sweep and owns the run state and the step counter.
   // It gates the control word so that the datapath only acts on it while a program runs.
   swd_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .command  (req_item.command),
      .status   (status),
      .rom_word (rom_word),
      .pc       (pc),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   // The datapath holds the record memory and the registers of the root walks,
   // and reports the flags that the conditional jumps test.
   swd_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .index_value (req_item.index_value),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

endmodule
